@@ hdl/hpt_pkg.sv @@
// shared types and constants for the homogeneous point transform
package hpt_pkg;

    localparam int COORD_WIDTH    = 32;
    localparam int COEF_WIDTH     = 32;
    localparam int CFG_ADDR_WIDTH = 4;
    localparam int CFG_DATA_WIDTH = 64;
    localparam int NUM_CFG_REGS   = 8;

    typedef enum logic
    {
        ACT_POINT  = 1'b0,
        ACT_VECTOR = 1'b1
    } action_t;

    typedef struct packed
    {
        action_t                        action;
        logic signed [COORD_WIDTH-1:0]  in_x;
        logic signed [COORD_WIDTH-1:0]  in_y;
        logic signed [COORD_WIDTH-1:0]  in_z;
    } hpt_in_t;

    typedef struct packed
    {
        logic signed [COORD_WIDTH-1:0]  out_x;
        logic signed [COORD_WIDTH-1:0]  out_y;
        logic signed [COORD_WIDTH-1:0]  out_z;
        logic                           w_zero;
    } hpt_out_t;

endpackage

@@ hdl/homogeneous_point_transform.sv @@
// Homogeneous 4x4 matrix transform of points and direction vectors
// Takes one transfer per cycle unless the output is blocked and returns one result per
// transfer, in order. Stages: a product stage, a sum stage, a sign and range prep stage, one
// stage per quotient bit of the three parallel restoring dividers, and an output stage.
// A blocked output stalls all stages; else the rate is one item per cycle. Matrix registers
// reset to identity and should be written only while the pipeline is empty.
module homogeneous_point_transform #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  hpt_pkg::hpt_in_t                       in_data,
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output hpt_pkg::hpt_out_t                      out_data,
    input  logic                                   cfg_we,
    input  logic [hpt_pkg::CFG_ADDR_WIDTH-1:0]     cfg_addr,
    input  logic [hpt_pkg::CFG_DATA_WIDTH-1:0]     cfg_wdata
);
    import hpt_pkg::*;

    localparam int CW = COORD_WIDTH;
    localparam int PW = COEF_WIDTH + CW;
    localparam int AW = PW + 2;
    localparam int NW = AW + FRAC_BITS;
    localparam logic signed [COEF_WIDTH-1:0] ONE = COEF_WIDTH'(1) << FRAC_BITS;
    localparam logic [CW-1:0] MAX_OUT = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] MIN_OUT = {1'b1, {(CW-1){1'b0}}};

    typedef struct packed
    {
        logic [2:0][AW-1:0] rem;
        logic [2:0][CW-1:0] nlow;
        logic [2:0][CW-1:0] quo;
        logic [AW-1:0]      dmag;
        logic [2:0]         neg;
        logic [2:0]         ovf;
        logic               wz;
        logic               vec;
        logic [2:0][CW-1:0] vres;
    } div_t;

    logic signed [COEF_WIDTH-1:0] coef_reg [4][4];

    logic                 en;
    logic                 p_valid_reg;
    logic signed [PW-1:0] prod_reg [4][3];
    logic signed [AW-1:0] trans_reg [4];
    logic                 p_vec_reg;

    logic                 a_valid_reg;
    logic signed [AW-1:0] acc_reg [4];
    logic                 a_vec_reg;

    logic                 d_valid_reg [CW+1];
    div_t                 div_reg [CW+1];
    div_t                 prep_next;

    logic                 out_valid_reg;
    hpt_out_t             out_reg;
    hpt_out_t             out_next;

    logic signed [CW-1:0] vin [3];

    function automatic logic [CW-1:0] sat_cw(input logic signed [AW-1:0] a);
        logic [CW-1:0] r;
        r = a[CW-1:0];
        if (!a[AW-1] && (|a[AW-2:CW-1]))
            r = MAX_OUT;
        else if (a[AW-1] && !(&a[AW-2:CW-1]))
            r = MIN_OUT;
        return r;
    endfunction

    function automatic div_t div_step(input div_t s);
        div_t        n;
        logic [AW:0] t;
        n = s;
        for (int c = 0; c < 3; c++)
        begin
            t = {s.rem[c], s.nlow[c][CW-1]};
            if (t >= {1'b0, s.dmag})
            begin
                t         = t - {1'b0, s.dmag};
                n.quo[c]  = {s.quo[c][CW-2:0], 1'b1};
            end
            else
            begin
                n.quo[c]  = {s.quo[c][CW-2:0], 1'b0};
            end
            n.rem[c]  = t[AW-1:0];
            n.nlow[c] = {s.nlow[c][CW-2:0], 1'b0};
        end
        return n;
    endfunction

    // matrix registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 4; r++)
                for (int c = 0; c < 4; c++)
                    coef_reg[r][c] <= (r == c) ? ONE : '0;
        end
        else if (cfg_we && (cfg_addr < CFG_ADDR_WIDTH'(NUM_CFG_REGS)))
        begin
            coef_reg[cfg_addr[2:1]][{cfg_addr[0], 1'b0}] <= cfg_wdata[31:0];
            coef_reg[cfg_addr[2:1]][{cfg_addr[0], 1'b1}] <= cfg_wdata[63:32];
        end
    end

    assign en        = !(out_valid_reg && out_stall);
    assign in_stall  = !en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign vin[0] = in_data.in_x;
    assign vin[1] = in_data.in_y;
    assign vin[2] = in_data.in_z;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg   <= 1'b0;
            a_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i <= CW; i++)
                d_valid_reg[i] <= 1'b0;
        end
        else if (en)
        begin
            p_valid_reg    <= in_valid;
            a_valid_reg    <= p_valid_reg;
            d_valid_reg[0] <= a_valid_reg;
            for (int i = 1; i <= CW; i++)
                d_valid_reg[i] <= d_valid_reg[i-1];
            out_valid_reg  <= d_valid_reg[CW];
        end
    end

    // prep: sign, magnitude and range of each division, and the saturated vector result
    always_comb
    begin
        logic signed [AW-1:0] sh;
        logic signed [NW-1:0] num;
        logic [NW-1:0]        nmag;
        prep_next      = '0;
        prep_next.vec  = a_vec_reg;
        prep_next.wz   = (acc_reg[3] == '0) && !a_vec_reg;
        prep_next.dmag = acc_reg[3][AW-1] ? AW'(-acc_reg[3]) : acc_reg[3];
        for (int c = 0; c < 3; c++)
        begin
            sh                = acc_reg[c] >>> FRAC_BITS;
            prep_next.vres[c] = sat_cw(sh);
            num               = NW'(acc_reg[c]) <<< FRAC_BITS;
            nmag              = num[NW-1] ? NW'(-num) : num;
            prep_next.neg[c]  = num[NW-1] ^ acc_reg[3][AW-1];
            prep_next.ovf[c]  = {{(AW+CW-NW){1'b0}}, nmag} >= {prep_next.dmag, {CW{1'b0}}};
            prep_next.rem[c]  = AW'(nmag >> CW);
            prep_next.nlow[c] = nmag[CW-1:0];
        end
    end

    // result select and saturation
    always_comb
    begin
        logic [2:0][CW-1:0] res;
        div_t               s;
        s = div_reg[CW];
        for (int c = 0; c < 3; c++)
        begin
            if (s.vec)
                res[c] = s.vres[c];
            else if (s.wz)
                res[c] = '0;
            else if (s.ovf[c])
                res[c] = s.neg[c] ? MIN_OUT : MAX_OUT;
            else if (!s.neg[c])
                res[c] = (s.quo[c] > MAX_OUT) ? MAX_OUT : s.quo[c];
            else
                res[c] = (s.quo[c] > MIN_OUT) ? MIN_OUT : CW'(-s.quo[c]);
        end
        out_next.out_x  = res[0];
        out_next.out_y  = res[1];
        out_next.out_z  = res[2];
        out_next.w_zero = s.wz;
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_vec_reg <= (in_data.action == ACT_VECTOR);
            for (int r = 0; r < 4; r++)
            begin
                for (int c = 0; c < 3; c++)
                    prod_reg[r][c] <= PW'(coef_reg[r][c]) * PW'(vin[c]);
                trans_reg[r] <= (in_data.action == ACT_VECTOR) ? '0
                              : (AW'(coef_reg[r][3]) <<< FRAC_BITS);
            end
            a_vec_reg <= p_vec_reg;
            for (int r = 0; r < 4; r++)
                acc_reg[r] <= AW'(prod_reg[r][0]) + AW'(prod_reg[r][1])
                            + AW'(prod_reg[r][2]) + trans_reg[r];
            div_reg[0] <= prep_next;
            for (int i = 1; i <= CW; i++)
                div_reg[i] <= div_step(div_reg[i-1]);
            out_reg <= out_next;
        end
    end

endmodule

@@ hdl/hpt_check.sv @@
// port-level checks for the homogeneous point transform
module hpt_check (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_stall,
    input  hpt_pkg::hpt_in_t                       in_data,
    input  logic                                   out_valid,
    input  logic                                   out_stall,
    input  hpt_pkg::hpt_out_t                      out_data
);
    import hpt_pkg::*;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output transfer changed while stalled");

    // stalled input transfer stays put
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_data))
        else $error("input transfer changed while stalled");

    // input only stalls behind a blocked result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output backpressure");

    // zero w forces zero coordinates
    a_wzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.w_zero |->
            out_data.out_x == '0 && out_data.out_y == '0 && out_data.out_z == '0)
        else $error("w_zero result with nonzero coordinates");

endmodule

bind homogeneous_point_transform hpt_check u_hpt_check (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
